// ===== rtl/mqva_pkg.sv =====
// ----------------------------------------------------------------------------
// mqva_pkg
// Shared types and constants of the modular vector ALU: operation codes,
// beat layouts and the per-stage advance group of the pipeline.
// ----------------------------------------------------------------------------
package mqva_pkg;

	localparam int OPND_W = 10;
	localparam int PROD_W = 2 * OPND_W;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
		logic              last;
	} req_t;

	typedef struct packed {
		logic [OPND_W-1:0] result;
		logic              last_out;
	} rsp_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

// ===== rtl/mqva_addsub.sv =====
// ----------------------------------------------------------------------------
// mqva_addsub
// Modular add and subtract with one conditional correction by the modulus.
// ----------------------------------------------------------------------------
module mqva_addsub #(
	parameter int MODULUS = 1021
) (
	input  logic [1:0]                   op,
	input  logic [mqva_pkg::OPND_W-1:0] a,
	input  logic [mqva_pkg::OPND_W-1:0] b,
	output logic [mqva_pkg::OPND_W-1:0] res
);
	import mqva_pkg::*;

	localparam int MW = $clog2(MODULUS + 1);
	localparam int AW = ((MW > OPND_W + 1) ? MW : OPND_W + 1) + 1;
	localparam logic [AW-1:0] MOD_A = AW'(MODULUS);

	logic [AW-1:0] sum;
	logic [AW-1:0] dif;
	logic [AW-1:0] sum_fix;
	logic [AW-1:0] dif_fix;

	always_comb begin
		sum     = AW'(a) + AW'(b) - MOD_A;
		dif     = AW'(a) - AW'(b);
		sum_fix = sum[AW-1] ? sum + MOD_A : sum;
		dif_fix = dif[AW-1] ? dif + MOD_A : dif;
		case (op_t'(op))
			OP_ADD:  res = sum_fix[OPND_W-1:0];
			OP_SUB:  res = dif_fix[OPND_W-1:0];
			default: res = '0;
		endcase
	end

endmodule

// ===== rtl/mqva_barrett.sv =====
// ----------------------------------------------------------------------------
// mqva_barrett
// Three-stage modular multiplier: product, Barrett quotient estimate,
// quotient times modulus; final subtract and one correction at the output.
// ----------------------------------------------------------------------------
module mqva_barrett #(
	parameter int MODULUS = 1021
) (
	input  logic                         clk,
	input  mqva_pkg::stage_en_t          en,
	input  logic [mqva_pkg::OPND_W-1:0] a,
	input  logic [mqva_pkg::OPND_W-1:0] b,
	output logic [mqva_pkg::OPND_W-1:0] res
);
	import mqva_pkg::*;

	localparam int MW   = $clog2(MODULUS + 1);
	localparam int K    = PROD_W + MW;
	localparam int MU_W = PROD_W + 2;
	localparam int QW   = PROD_W + MU_W - K;
	localparam logic [MU_W-1:0] MU = MU_W'((64'd1 << K) / 64'(MODULUS));
	localparam logic [MW-1:0] MOD_M = MW'(MODULUS);
	localparam logic [PROD_W-1:0] MOD_P = PROD_W'(MODULUS);

	logic [PROD_W-1:0]      p_s1;
	logic [PROD_W-1:0]      p_s2;
	logic [PROD_W-1:0]      p_s3;
	logic [QW-1:0]          q_s2;
	logic [PROD_W-1:0]      qm_s3;
	logic [PROD_W+MU_W-1:0] t;
	logic [QW+MW-1:0]       qm;
	logic [PROD_W-1:0]      r;
	logic [PROD_W-1:0]      r_fix;

	always_comb begin
		t     = (PROD_W + MU_W)'(p_s1) * (PROD_W + MU_W)'(MU);
		qm    = (QW + MW)'(q_s2) * (QW + MW)'(MOD_M);
		r     = p_s3 - qm_s3;
		r_fix = (r >= MOD_P) ? r - MOD_P : r;
		res   = r_fix[OPND_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_s1 <= PROD_W'(a) * PROD_W'(b);
		end
		if (en.s2) begin
			p_s2 <= p_s1;
			q_s2 <= t[K +: QW];
		end
		if (en.s3) begin
			p_s3  <= p_s2;
			qm_s3 <= qm[PROD_W-1:0];
		end
	end

endmodule

// ===== rtl/mod_q_vector_alu.sv =====
// ----------------------------------------------------------------------------
// mod_q_vector_alu
// Element-wise multiply, add and subtract of residues modulo MODULUS.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per element (op, a, b, last), taken when req_valid
//   is high and req_stall is low. rsp channel: one beat per request beat
//   (result, last_out), in order, taken when rsp_valid is high and rsp_stall
//   is low.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   four-stage datapath is set by the Barrett multiplier (product, quotient
//   estimate, quotient times modulus, final correction), each stage holding
//   one multiply or one subtract-compare.
//   A stage moves whenever the stage after it is empty or moving, so bubbles
//   close up; req_stall rises only when all four stages are full and the
//   receiver stalls, and no beat is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty and ready at once.
//   Operation code 3 returns zero. Operands are expected in 0..MODULUS-1.
// ----------------------------------------------------------------------------
module mod_q_vector_alu #(
	parameter int MODULUS = 1021
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mqva_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mqva_pkg::rsp_t rsp
);
	import mqva_pkg::*;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [1:0]        op_s1, op_s2, op_s3;
	logic [OPND_W-1:0] as_s1, as_s2, as_s3;
	logic              last_s1, last_s2, last_s3;
	rsp_t              rsp_s4;
	logic [OPND_W-1:0] as_res;
	logic [OPND_W-1:0] mul_res;
	logic              en4;
	stage_en_t         en;

	always_comb begin
		en4       = !v_s4 || !rsp_stall;
		en.s3     = !v_s3 || en4;
		en.s2     = !v_s2 || en.s3;
		en.s1     = !v_s1 || en.s2;
		req_stall = !en.s1;
		rsp_valid = v_s4;
		rsp       = rsp_s4;
	end

	mqva_addsub #(.MODULUS(MODULUS)) u_addsub (
		.op  (req.op),
		.a   (req.a),
		.b   (req.b),
		.res (as_res)
	);

	mqva_barrett #(.MODULUS(MODULUS)) u_barrett (
		.clk (clk),
		.en  (en),
		.a   (req.a),
		.b   (req.b),
		.res (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= req_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en4)   v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1   <= req.op;
			as_s1   <= as_res;
			last_s1 <= req.last;
		end
		if (en.s2) begin
			op_s2   <= op_s1;
			as_s2   <= as_s1;
			last_s2 <= last_s1;
		end
		if (en.s3) begin
			op_s3   <= op_s2;
			as_s3   <= as_s2;
			last_s3 <= last_s2;
		end
		if (en4) begin
			rsp_s4.result   <= (op_t'(op_s3) == OP_MUL) ? mul_res : as_s3;
			rsp_s4.last_out <= last_s3;
		end
	end

endmodule
